// ----- sv/png_unf_pkg.sv -----
// Shared types and constants of the PNG scanline unfilter.
// Used by the channel interfaces' users, the config block, the predictor and the top level.
`default_nettype none

package png_unf_pkg;

  localparam int MAX_LINE_BYTES  = 8192;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int POS_W  = $clog2(MAX_LINE_BYTES);   // line store address
  localparam int LEN_W  = 14;                       // line_bytes register
  localparam int BPP_W  = 4;                        // bytes_per_pixel register
  localparam int HIST_W = $clog2(MAX_PIXEL_BYTES);  // left history index

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register indexes (byte address / 4)
  localparam logic REG_LINE_BYTES = 1'b0;
  localparam logic REG_BPP        = 1'b1;

  localparam logic [7:0] FILTER_MAX = 8'd4;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  // clamped register values as the datapath sees them
  typedef struct packed {
    logic [LEN_W-1:0] line_len;   // 1 .. MAX_LINE_BYTES
    logic [BPP_W-1:0] bpp;        // 1 .. MAX_PIXEL_BYTES
  } cfg_t;

endpackage

`default_nettype wire

// ----- sv/png_unf_if.sv -----
// Valid/ready channel interfaces of the PNG scanline unfilter.
// Input channel carries stream bytes, output channel carries reconstructed bytes.
`default_nettype none

interface png_unf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface png_unf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       row_end;
  logic       bad_filter;

  modport source (output valid, output pixel_byte, output row_end, output bad_filter,
                  input ready);
  modport sink   (input valid, input pixel_byte, input row_end, input bad_filter,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/png_unf_cfg.sv -----
// APB register block of the PNG scanline unfilter: line_bytes and bytes_per_pixel.
// Depends on png_unf_pkg; hands clamped values to the datapath as cfg_t.
`default_nettype none

module png_unf_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [png_unf_pkg::PADDR_W-1:0] paddr,
  input  logic [png_unf_pkg::PDATA_W-1:0] pwdata,
  output logic [png_unf_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output png_unf_pkg::cfg_t             cfg
);
  import png_unf_pkg::*;

  logic [LEN_W-1:0] line_bytes;
  logic [BPP_W-1:0] bytes_per_pixel;
  logic             wr_en;
  logic             reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes      <= LEN_W'(1);
      bytes_per_pixel <= BPP_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LINE_BYTES: line_bytes      <= pwdata[LEN_W-1:0];
        REG_BPP:        bytes_per_pixel <= pwdata[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LINE_BYTES: prdata = PDATA_W'(line_bytes);
      REG_BPP:        prdata = PDATA_W'(bytes_per_pixel);
      default:        prdata = '0;
    endcase
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (line_bytes == '0)
      cfg.line_len = LEN_W'(1);
    else if (line_bytes > LEN_W'(MAX_LINE_BYTES))
      cfg.line_len = LEN_W'(MAX_LINE_BYTES);
    else
      cfg.line_len = line_bytes;

    if (bytes_per_pixel == '0)
      cfg.bpp = BPP_W'(1);
    else if (bytes_per_pixel > BPP_W'(MAX_PIXEL_BYTES))
      cfg.bpp = BPP_W'(MAX_PIXEL_BYTES);
    else
      cfg.bpp = bytes_per_pixel;
  end

endmodule

`default_nettype wire

// ----- sv/png_unf_recon.sv -----
// Byte reconstruction of the PNG filters None, Sub, Up, Average and Paeth.
// Depends on png_unf_pkg for the filter codes; purely combinational.
`default_nettype none

module png_unf_recon (
  input  png_unf_pkg::filter_t filter,
  input  logic [7:0]           filt_byte,
  input  logic [7:0]           left,
  input  logic [7:0]           above,
  input  logic [7:0]           above_left,
  output logic [7:0]           recon_byte
);
  import png_unf_pkg::*;

  logic signed [9:0] d_ab, d_bc, d_abc;
  logic        [9:0] pa, pb, pc;
  logic        [8:0] avg_sum;
  logic        [7:0] paeth;
  logic        [7:0] pred;

  // p - a = b - c, p - b = a - c, p - c = a + b - 2c
  always_comb begin
    d_ab  = $signed({2'b00, above}) - $signed({2'b00, above_left});
    d_bc  = $signed({2'b00, left})  - $signed({2'b00, above_left});
    d_abc = d_ab + d_bc;
    pa    = d_ab[9]  ? 10'(-d_ab)  : 10'(d_ab);
    pb    = d_bc[9]  ? 10'(-d_bc)  : 10'(d_bc);
    pc    = d_abc[9] ? 10'(-d_abc) : 10'(d_abc);
    if (pa <= pb && pa <= pc)
      paeth = left;
    else if (pb <= pc)
      paeth = above;
    else
      paeth = above_left;
  end

  assign avg_sum = {1'b0, left} + {1'b0, above};

  always_comb begin
    case (filter)
      FILT_SUB:   pred = left;
      FILT_UP:    pred = above;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth;
      default:    pred = 8'd0;
    endcase
  end

  assign recon_byte = filt_byte + pred;

endmodule

`default_nettype wire

// ----- sv/png_unf_core_top.sv -----
// Top level of the PNG scanline unfilter: line memory, predictor stage, output register.
// Depends on png_unf_pkg, png_unf_if, png_unf_cfg and png_unf_recon.
//
//  channel   dir  transfer        payload
//  in_ch     in   valid & ready   data_byte[7:0], frame_start
//  out_ch    out  valid & ready   pixel_byte[7:0], row_end, bad_filter
//  apb       in   psel & penable  paddr[2:0], pwdata[31:0] -> prdata[31:0]
//
// One byte per cycle sustained while out_ch is ready. A data byte is captured together with
// its line memory read data at its transfer edge, is held in the predictor stage until the
// output register can take it, and is then presented from the output register. Filter type
// bytes are taken but leave no result.
// Reset clears positions, flags and the neighbor history; the line memory is not cleared.
// A full output register stalls the predictor stage, and that stalls the input.
`default_nettype none

module png_scanline_unfilter_core (
  input  logic                           clk,
  input  logic                           rst,
  png_unf_in_if.sink                     in_ch,
  png_unf_out_if.source                  out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [png_unf_pkg::PADDR_W-1:0] paddr,
  input  logic [png_unf_pkg::PDATA_W-1:0] pwdata,
  output logic [png_unf_pkg::PDATA_W-1:0] prdata,
  output logic                           pready
);
  import png_unf_pkg::*;

  cfg_t cfg;

  png_unf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // line state
  logic [POS_W-1:0] byte_position;
  filter_t          line_filter;
  logic             expect_filter_byte;
  logic             first_row;
  logic             line_error;

  // predictor stage
  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic [POS_W-1:0] s1_pos;
  filter_t          s1_filter;
  logic             s1_first;
  logic             s1_err;
  logic             s1_last;
  logic             s1_edge;

  // line memory and read path
  logic [7:0]       line_mem [MAX_LINE_BYTES];
  logic [7:0]       rd_data;
  logic             fwd_hit;
  logic [7:0]       fwd_byte;

  logic [7:0]       left_history       [MAX_PIXEL_BYTES];
  logic [7:0]       above_left_history [MAX_PIXEL_BYTES];

  logic             out_valid;
  logic [7:0]       pixel_byte;
  logic             row_end;
  logic             bad_filter;

  logic             accept, accept_filt, accept_data, advance;
  logic             exp_eff, first_eff;
  logic [POS_W-1:0] pos_eff;
  logic [LEN_W-1:0] pos_plus1;
  logic             last0, edge0;
  logic [HIST_W-1:0] hist_idx;
  logic [7:0]       a_byte, b_byte, c_byte, v_byte;

  // stage control
  assign advance     = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;
  assign accept      = in_ch.valid && in_ch.ready;

  // frame start forces a filter byte of a first row
  assign exp_eff     = in_ch.frame_start || expect_filter_byte;
  assign first_eff   = in_ch.frame_start || first_row;
  assign pos_eff     = in_ch.frame_start ? '0 : byte_position;
  assign accept_filt = accept && exp_eff;
  assign accept_data = accept && !exp_eff;

  assign pos_plus1   = {1'b0, pos_eff} + LEN_W'(1);
  assign last0       = pos_plus1 >= cfg.line_len;
  assign edge0       = pos_eff < POS_W'(cfg.bpp);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      line_filter        <= FILT_NONE;
      expect_filter_byte <= 1'b1;
      first_row          <= 1'b1;
      line_error         <= 1'b0;
    end else if (accept_filt) begin
      if (in_ch.data_byte > FILTER_MAX) begin
        line_filter <= FILT_NONE;
        line_error  <= 1'b1;
      end else begin
        line_filter <= filter_t'(in_ch.data_byte[2:0]);
        line_error  <= 1'b0;
      end
      expect_filter_byte <= 1'b0;
      first_row          <= first_eff;
      byte_position      <= '0;
    end else if (accept_data) begin
      if (last0) begin
        expect_filter_byte <= 1'b1;
        first_row          <= 1'b0;
        byte_position      <= '0;
      end else begin
        byte_position <= pos_plus1[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept_data) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_data) begin
      s1_byte   <= in_ch.data_byte;
      s1_pos    <= pos_eff;
      s1_filter <= line_filter;
      s1_first  <= first_row;
      s1_err    <= line_error;
      s1_last   <= last0;
      s1_edge   <= edge0;
    end
  end

  // read at accept, write back when the byte leaves the predictor stage
  always_ff @(posedge clk) begin
    if (advance) begin
      line_mem[s1_pos] <= v_byte;
    end
    if (accept_data) begin
      rd_data  <= line_mem[pos_eff];
      fwd_hit  <= advance && (s1_pos == pos_eff);
      fwd_byte <= v_byte;
    end
  end

  assign hist_idx = HIST_W'(cfg.bpp - BPP_W'(1));

  always_comb begin
    if (s1_first)
      b_byte = 8'd0;
    else if (fwd_hit)
      b_byte = fwd_byte;
    else
      b_byte = rd_data;
    a_byte = s1_edge ? 8'd0 : left_history[hist_idx];
    c_byte = s1_edge ? 8'd0 : above_left_history[hist_idx];
  end

  png_unf_recon u_recon (
    .filter     (s1_filter),
    .filt_byte  (s1_byte),
    .left       (a_byte),
    .above      (b_byte),
    .above_left (c_byte),
    .recon_byte (v_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_history[i]       <= 8'd0;
        above_left_history[i] <= 8'd0;
      end
    end else if (advance) begin
      left_history[0]       <= v_byte;
      above_left_history[0] <= b_byte;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_history[i]       <= left_history[i-1];
        above_left_history[i] <= above_left_history[i-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_byte <= v_byte;
      row_end    <= s1_last;
      bad_filter <= s1_err;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.pixel_byte = pixel_byte;
  assign out_ch.row_end    = row_end;
  assign out_ch.bad_filter = bad_filter;

  // input only backs up behind an occupied predictor stage
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> s1_valid && out_valid)
    else $error("input stalled without a pending byte");

  // a row-ending data byte leaves the line expecting a filter byte
  a_row_close: assert property (@(posedge clk) disable iff (rst)
    accept_data && last0 |=> expect_filter_byte && s1_valid && s1_last)
    else $error("row end did not close the line");

  // a new result only appears after the predictor stage held a byte
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result without a byte in the predictor stage");

  // a stalled predictor stage keeps its byte and its read data
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_pos) && $stable(rd_data))
    else $error("predictor stage lost its byte while stalled");

endmodule

`default_nettype wire

// ----- sim/png_scanline_unfilter_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for png_scanline_unfilter_core: random PNG scanline streams,
// byte-accurate prediction of None/Sub/Up/Average/Paeth reconstruction, APB setup.
// Depends on png_unf_pkg, png_unf_if and the core's sources.

module png_scanline_unfilter_core_test;
  import png_unf_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_ROW_BYTES = 400;
  localparam logic [7:0] BAD_FILTER_TYPE = 8'hFF;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       bad_filter;
  } pix_result_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  png_unf_in_if  in_ch ();
  png_unf_out_if out_ch ();

  png_scanline_unfilter_core DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [7:0]       prev_line [MAX_LINE_BYTES];
  logic [7:0]       left_hist [8];
  logic [7:0]       above_hist [8];
  int unsigned      line_pos = 0;
  filter_t          cur_filter = FILT_NONE;
  bit               want_filter = 1'b1;
  bit               top_row = 1'b1;
  bit               line_bad = 1'b0;
  logic [LEN_W-1:0] cfg_line_bytes = 1;
  logic [BPP_W-1:0] cfg_bpp = 1;

  pix_result_t pending_pixels [$];
  int          bytes_sent = 0;
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_requests = 0;
  int          quiet_cycles = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int unsigned line_len_now();
    if (cfg_line_bytes == 0) return 1;
    if (cfg_line_bytes > MAX_LINE_BYTES) return MAX_LINE_BYTES;
    return cfg_line_bytes;
  endfunction

  function automatic logic [7:0] paeth_choose(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int p, da, db, dc;
    p  = int'(a) + int'(b) - int'(c);
    da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
    db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
    dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // returns 1 when the byte reconstructs to a pixel byte
  function automatic bit unfilter_byte(input logic [7:0] d, input logic fs,
                                       output pix_result_t res);
    int unsigned len, bpp, p;
    logic [7:0]  a, b, c, pred, v;
    logic [8:0]  sum;
    len = line_len_now();
    bpp = (cfg_bpp == 0) ? 1 : (cfg_bpp > MAX_PIXEL_BYTES ? MAX_PIXEL_BYTES : cfg_bpp);
    res = '0;
    if (fs) begin
      want_filter = 1'b1;
      top_row = 1'b1;
      line_pos = 0;
    end
    if (want_filter) begin
      if (d > FILTER_MAX) begin
        cur_filter = FILT_NONE;
        line_bad = 1'b1;
      end else begin
        cur_filter = filter_t'(d[2:0]);
        line_bad = 1'b0;
      end
      want_filter = 1'b0;
      line_pos = 0;
      return 1'b0;
    end
    p = (line_pos >= MAX_LINE_BYTES) ? MAX_LINE_BYTES - 1 : line_pos;
    b = top_row ? 8'h00 : prev_line[p];
    // left neighbors are zero inside the first pixel
    if (p >= bpp) begin
      a = left_hist[bpp-1];
      c = above_hist[bpp-1];
    end else begin
      a = 8'h00;
      c = 8'h00;
    end
    sum = {1'b0, a} + {1'b0, b};
    case (cur_filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = sum[8:1];
      FILT_PAETH: pred = paeth_choose(a, b, c);
      default:    pred = 8'h00;
    endcase
    v = d + pred;
    for (int i = 7; i > 0; i--) begin
      left_hist[i]  = left_hist[i-1];
      above_hist[i] = above_hist[i-1];
    end
    left_hist[0]  = v;
    above_hist[0] = b;
    prev_line[p]  = v;
    res.pixel_byte = v;
    res.row_end    = (p + 1 >= len);
    res.bad_filter = line_bad;
    if (res.row_end) begin
      want_filter = 1'b1;
      top_row = 1'b0;
      line_pos = 0;
    end else begin
      line_pos = p + 1;
    end
    return 1'b1;
  endfunction

  function automatic void note_failure(string what, logic [7:0] want_v, logic [7:0] got_v);
    if (fail_count < 10)
      $display("mismatch %s: expected %h, got %h at %0t", what, want_v, got_v, $time);
    fail_count++;
  endfunction

  function automatic logic [7:0] pick_filter();
    if ($urandom_range(7) == 0) return 8'($urandom_range(FILTER_MAX + 1, 255));
    return 8'($urandom_range(FILT_NONE, FILT_PAETH));
  endfunction

  task automatic apb_write(input logic reg_idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_LINE_BYTES) cfg_line_bytes = value[LEN_W-1:0];
    else cfg_bpp = value[BPP_W-1:0];
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] d, input logic fs);
    pix_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= d;
    in_ch.frame_start <= fs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (unfilter_byte(d, fs, res)) pending_pixels = {pending_pixels, res};
    bytes_sent++;
  endtask

  task automatic send_row(input logic [7:0] filt, input logic fs, input int n);
    send_byte(filt, fs);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  // whole frame at the current line length, with an occasional restart mid-line
  task automatic send_frame(input int rows);
    int len;
    len = line_len_now();
    send_byte(pick_filter(), 1'b1);
    for (int r = 0; r < rows; r++) begin
      if (r != 0) send_byte(pick_filter(), 1'b0);
      for (int i = 0; i < len; i++)
        send_byte(8'($urandom), ($urandom_range(59) == 0));
    end
  endtask

  // wait for every pixel byte, then let filter-type transfers drain too
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_config();
    send_row(FILT_NONE, 1'b1, 0);
    send_byte(8'hFF, 1'b0);
    send_row(FILT_UP, 1'b0, 0);
    send_byte(8'h01, 1'b0);   // wraps to zero
  endtask

  task automatic test_each_filter();
    settle();
    apb_write(REG_LINE_BYTES, 2);
    apb_write(REG_BPP, 1);
    send_row(FILT_NONE, 1'b1, 2);
    send_row(FILT_SUB, 1'b0, 2);
    send_row(FILT_UP, 1'b0, 2);
    send_row(FILT_AVG, 1'b0, 2);
    send_row(FILT_PAETH, 1'b0, 2);
    send_row(BAD_FILTER_TYPE, 1'b0, 2);
  endtask

  task automatic test_frame_restart();
    send_row(FILT_SUB, 1'b1, 1);
    send_row(FILT_AVG, 1'b1, 2);
  endtask

  task automatic test_register_clamp();
    settle();
    apb_write(REG_LINE_BYTES, 0);
    apb_write(REG_BPP, 0);
    send_row(FILT_SUB, 1'b1, 1);
    send_row(FILT_UP, 1'b0, 1);
  endtask

  task automatic test_midline_shrink();
    settle();
    apb_write(REG_LINE_BYTES, 6);
    apb_write(REG_BPP, 2);
    send_row(FILT_PAETH, 1'b1, 3);
    settle();
    apb_write(REG_LINE_BYTES, 1);
    send_byte(8'($urandom), 1'b0);   // position already past the new length
  endtask

  // oversize registers clamp to the maximum; a long row, cut short by the next frame
  task automatic test_long_line();
    settle();
    recv_idle_pct = 20;
    apb_write(REG_LINE_BYTES, (1 << LEN_W) - 1);
    apb_write(REG_BPP, (1 << BPP_W) - 1);
    send_row(FILT_PAETH, 1'b1, LONG_ROW_BYTES);
    settle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apb_write(REG_LINE_BYTES, 8);
    apb_write(REG_BPP, 3);
    hold_requests++;
    send_frame(4);
    settle();
  endtask

  task automatic test_random_stream(input int send_pct, input int recv_pct, input int items);
    int stop_at, len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = bytes_sent + items;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(1) == 0) begin
        settle();
        case ($urandom_range(9)) inside
          0:       len = 0;
          [1:2]:   len = $urandom_range(13, 48);
          default: len = $urandom_range(1, 12);
        endcase
        apb_write(REG_LINE_BYTES, len);
        apb_write(REG_BPP, ($urandom_range(4) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(1, 8));
      end
      send_frame($urandom_range(1, 5));
    end
    settle();
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int holds_served, hold_left;
    holds_served = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    pix_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        note_failure("unexpected transfer, pixel_byte", 8'h00, out_ch.pixel_byte);
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.pixel_byte !== want.pixel_byte)
          note_failure("pixel_byte", want.pixel_byte, out_ch.pixel_byte);
        if (out_ch.row_end !== want.row_end)
          note_failure("row_end", 8'(want.row_end), 8'(out_ch.row_end));
        if (out_ch.bad_filter !== want.bad_filter)
          note_failure("bad_filter", 8'(want.bad_filter), 8'(out_ch.bad_filter));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL png_scanline_unfilter_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.frame_start = 1'b0;
    for (int i = 0; i < 8; i++) begin
      left_hist[i] = 8'h00;
      above_hist[i] = 8'h00;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_config();
    test_each_filter();
    test_frame_restart();
    test_register_clamp();
    test_midline_shrink();
    test_long_line();
    test_backpressure();
    test_random_stream(30, 61, 250);
    test_random_stream(61, 30, 250);
    test_random_stream(0, 0, 250);

    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("PASS png_scanline_unfilter_core");
    end else begin
      $display("FAIL png_scanline_unfilter_core");
    end
    $finish;
  end

endmodule
